// ===== hdl/point_defect_rate_euler_step_core_macros.svh =====
// assertion macros for the point defect rate euler step core
// used by pdre_mul and pdre_seq, expects clk and rst_n in scope
`ifndef POINT_DEFECT_RATE_EULER_STEP_CORE_MACROS_SVH
`define POINT_DEFECT_RATE_EULER_STEP_CORE_MACROS_SVH
`ifndef SYNTH
`define PDRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PDRE_ASSERT(lbl, prop, msg)
`define PDRE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/pdre_pkg.sv =====
// shared types, register indexes and saturating add/subtract for the euler step core
// no dependencies
package pdre_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GEN_I   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_V   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOMB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_I  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_V  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP   = 3'd5;

  localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KCI,
    S_RCV,
    S_LI,
    S_LV,
    S_DTI,
    S_DTV,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] gen_i;
    logic signed [31:0] gen_v;
    logic [30:0]        recomb;
    logic [30:0]        loss_i;
    logic [30:0]        loss_v;
    logic [30:0]        tstep;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic               hit;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_res_t;

  function automatic sat_res_t sat_addsub(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic sub);
    logic [32:0] s;
    sat_res_t    r;
    if (sub) begin
      s = {a[31], a} - {b[31], b};
    end else begin
      s = {a[31], a} + {b[31], b};
    end
    r.hit = s[32] ^ s[31];
    if (r.hit) begin
      r.val = s[32] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/point_defect_rate_euler_step_core.sv =====
// point defect rate equations, one forward euler step per item
// each step issues six products through one multiplier, in states S_KCI to S_DTV
// a new item is taken only once the previous step has finished, as all products share the single multiplier
// a finished result is held in an output register until taken; the next item may enter as the result moves into it
// reset (synchronous, active low): levels cleared, registers to their default rates
// depends on pdre_pkg, pdre_cfg, pdre_mul and pdre_seq
module point_defect_rate_euler_step_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pdre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_interstitial_conc,
  output logic signed [31:0]             out_vacancy_conc,
  output logic                           out_saturated
);
  import pdre_pkg::*;

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  pdre_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdre_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  pdre_seq u_seq (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_restart            (in_restart),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_interstitial_conc (out_interstitial_conc),
    .out_vacancy_conc      (out_vacancy_conc),
    .out_saturated         (out_saturated),
    .mreq                  (mreq),
    .mrsp                  (mrsp)
  );

endmodule

// ===== hdl/pdre_cfg.sv =====
// configuration register file of the euler step core
// depends on pdre_pkg
module pdre_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [pdre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata,
  output pdre_pkg::cfg_t                   cfg
);
  import pdre_pkg::*;

  localparam int GEN_RST    = ((1 << FRAC_BITS) + 5) / 10;
  localparam int RECOMB_RST = (1 << FRAC_BITS) / 2;
  localparam int TSTEP_RST  = ((1 << FRAC_BITS) + 50) / 100;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_GEN_I:  cfg_nxt.gen_i  = cfg_wdata;
        REG_GEN_V:  cfg_nxt.gen_v  = cfg_wdata;
        REG_RECOMB: cfg_nxt.recomb = cfg_wdata[30:0];
        REG_LOSS_I: cfg_nxt.loss_i = cfg_wdata[30:0];
        REG_LOSS_V: cfg_nxt.loss_v = cfg_wdata[30:0];
        REG_TSTEP:  cfg_nxt.tstep  = cfg_wdata[30:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen_i  <= 32'(GEN_RST);
      cfg_r.gen_v  <= 32'(GEN_RST);
      cfg_r.recomb <= 31'(RECOMB_RST);
      cfg_r.loss_i <= '0;
      cfg_r.loss_v <= '0;
      cfg_r.tstep  <= 31'(TSTEP_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/pdre_mul.sv =====
// shared fixed point multiplier: registered product, then floor shift and clamp
// depends on pdre_pkg and the macros header
module pdre_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pdre_pkg::mul_req_t req,
  output pdre_pkg::mul_rsp_t rsp
);
  import pdre_pkg::*;
  `include "point_defect_rate_euler_step_core_macros.svh"

  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] shifted;
  logic               over_hi, over_lo;

  assign prod_nxt = req.en ? (64'(req.a) * 64'(req.b)) : prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  assign shifted = prod_r >>> FRAC_BITS;
  assign over_hi = shifted > WMAX;
  assign over_lo = shifted < WMIN;

  always_comb begin
    rsp.hit = over_hi | over_lo;
    if (over_hi) begin
      rsp.res = FX_MAX;
    end else if (over_lo) begin
      rsp.res = FX_MIN;
    end else begin
      rsp.res = shifted[31:0];
    end
  end

  `PDRE_ASSERT_NXT(a_mul_hold, !req.en, $stable(prod_r), "product changed without issue")
  `PDRE_ASSERT(a_mul_clamp, !(over_hi && over_lo), "product clamped both ways")
  `PDRE_ASSERT(a_mul_hit, rsp.hit || (64'(rsp.res) == shifted), "unclamped result mismatch")

endmodule

// ===== hdl/pdre_seq.sv =====
// step sequencer: drives the shared multiplier, saturating sums, state and result register
// depends on pdre_pkg and the macros header
module pdre_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  pdre_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_interstitial_conc,
  output logic signed [31:0]  out_vacancy_conc,
  output logic                out_saturated,
  output pdre_pkg::mul_req_t  mreq,
  input  pdre_pkg::mul_rsp_t  mrsp
);
  import pdre_pkg::*;
  `include "point_defect_rate_euler_step_core_macros.svh"

  state_t             state_r, state_nxt;
  logic signed [31:0] ci_r, ci_nxt;
  logic signed [31:0] cv_r, cv_nxt;
  logic signed [31:0] recomb_r, recomb_nxt;
  logic signed [31:0] rate_i_r, rate_i_nxt;
  logic signed [31:0] rate_v_r, rate_v_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_ic_r, out_ic_nxt;
  logic signed [31:0] out_vc_r, out_vc_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic               slot_free;
  logic               accept;
  sat_res_t           s1, s2;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && slot_free);
  assign accept    = in_valid && in_ready;

  // first difference of each rate, and the final state sums
  always_comb begin
    case (state_r)
      S_LV:    s1 = sat_addsub(cfg.gen_i, recomb_r, 1'b1);
      S_DTI:   s1 = sat_addsub(cfg.gen_v, recomb_r, 1'b1);
      S_DTV:   s1 = sat_addsub(ci_r, mrsp.res, 1'b0);
      S_FIN:   s1 = sat_addsub(cv_r, mrsp.res, 1'b0);
      default: s1 = '0;
    endcase
  end

  assign s2 = sat_addsub(s1.val, mrsp.res, 1'b1);

  always_comb begin
    state_nxt     = state_r;
    ci_nxt        = ci_r;
    cv_nxt        = cv_r;
    recomb_nxt    = recomb_r;
    rate_i_nxt    = rate_i_r;
    rate_v_nxt    = rate_v_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ic_nxt    = out_ic_r;
    out_vc_nxt    = out_vc_r;
    out_sat_nxt   = out_sat_r;
    mreq.en       = 1'b0;
    mreq.a        = '0;
    mreq.b        = '0;

    case (state_r)
      S_IDLE: begin
      end
      S_KCI: begin
        mreq = '{en: 1'b1, a: {1'b0, cfg.recomb}, b: ci_r};
        state_nxt = S_RCV;
      end
      S_RCV: begin
        mreq = '{en: 1'b1, a: mrsp.res, b: cv_r};
        sat_nxt = sat_r | mrsp.hit;
        state_nxt = S_LI;
      end
      S_LI: begin
        mreq = '{en: 1'b1, a: {1'b0, cfg.loss_i}, b: ci_r};
        recomb_nxt = mrsp.res;
        sat_nxt = sat_r | mrsp.hit;
        state_nxt = S_LV;
      end
      S_LV: begin
        mreq = '{en: 1'b1, a: {1'b0, cfg.loss_v}, b: cv_r};
        rate_i_nxt = s2.val;
        sat_nxt = sat_r | mrsp.hit | s1.hit | s2.hit;
        state_nxt = S_DTI;
      end
      S_DTI: begin
        mreq = '{en: 1'b1, a: rate_i_r, b: {1'b0, cfg.tstep}};
        rate_v_nxt = s2.val;
        sat_nxt = sat_r | mrsp.hit | s1.hit | s2.hit;
        state_nxt = S_DTV;
      end
      S_DTV: begin
        mreq = '{en: 1'b1, a: rate_v_r, b: {1'b0, cfg.tstep}};
        ci_nxt = s1.val;
        sat_nxt = sat_r | mrsp.hit | s1.hit;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cv_nxt = s1.val;
        sat_nxt = sat_r | mrsp.hit | s1.hit;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ic_nxt    = ci_r;
          out_vc_nxt    = cv_r;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new item: optional restart, then the first product
    if (accept) begin
      if (in_restart) begin
        ci_nxt = '0;
        cv_nxt = '0;
      end
      sat_nxt   = 1'b0;
      state_nxt = S_KCI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ci_r        <= '0;
      cv_r        <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ci_r        <= ci_nxt;
      cv_r        <= cv_nxt;
      sat_r       <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    recomb_r  <= recomb_nxt;
    rate_i_r  <= rate_i_nxt;
    rate_v_r  <= rate_v_nxt;
    out_ic_r  <= out_ic_nxt;
    out_vc_r  <= out_vc_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_interstitial_conc = out_ic_r;
  assign out_vacancy_conc      = out_vc_r;
  assign out_saturated         = out_sat_r;

  `PDRE_ASSERT_NXT(a_seq_start, accept, state_r == S_KCI, "accepted item did not start")
  `PDRE_ASSERT(a_seq_busy, (state_r == S_IDLE) || (state_r == S_DONE) || !in_ready, "ready mid step")
  `PDRE_ASSERT_NXT(a_seq_done, (state_r == S_DONE) && slot_free, out_valid_r && (out_ic_r == $past(ci_r)), "finished step not presented")
  `PDRE_ASSERT_NXT(a_seq_restart, accept && in_restart && !$past(accept), state_r == S_KCI && ci_r == 32'sd0 && cv_r == 32'sd0, "restart did not clear levels")

endmodule

// ===== dv/pdre_step_checker.sv =====
// result checker for the point defect rate euler step core
// mirrors register writes and levels, predicts every step and compares each result taken
// depends on pdre_pkg
module pdre_step_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pdre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_restart,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             out_interstitial_conc,
  input  logic signed [31:0]             out_vacancy_conc,
  input  logic                           out_saturated,
  output int                             fail_count,
  output int                             pending
);
  import pdre_pkg::*;

  localparam longint FX_TOP    = 64'sd2147483647;
  localparam longint FX_BOTTOM = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] interstitial;
    logic signed [31:0] vacancy;
    logic               saturated;
  } step_result_t;

  cfg_t               rates;
  logic signed [31:0] interstitial_level;
  logic signed [31:0] vacancy_level;
  bit                 clamp_seen;
  step_result_t       step_q[$];
  step_result_t       want;
  int                 taken;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > FX_TOP) begin
      clamp_seen = 1'b1;
      return FX_MAX;
    end
    if (x < FX_BOTTOM) begin
      clamp_seen = 1'b1;
      return FX_MIN;
    end
    return x[31:0];
  endfunction

  // full product, floored by the arithmetic shift, then clamped
  function automatic logic signed [31:0] fx_product(input longint a, input longint b);
    return clamp32((a * b) >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] fx_sum(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  function automatic logic signed [31:0] fx_diff(input longint a, input longint b);
    return clamp32(a - b);
  endfunction

  function automatic step_result_t predict_step(input logic restart);
    logic signed [31:0] ci;
    logic signed [31:0] cv;
    logic signed [31:0] recomb;
    logic signed [31:0] loss_i;
    logic signed [31:0] loss_v;
    logic signed [31:0] rate_i;
    logic signed [31:0] rate_v;
    step_result_t       r;
    clamp_seen = 1'b0;
    if (restart) begin
      interstitial_level = '0;
      vacancy_level      = '0;
    end
    ci     = interstitial_level;
    cv     = vacancy_level;
    recomb = fx_product(fx_product(rates.recomb, ci), cv);
    loss_i = fx_product(rates.loss_i, ci);
    loss_v = fx_product(rates.loss_v, cv);
    rate_i = fx_diff(fx_diff($signed(rates.gen_i), recomb), loss_i);
    rate_v = fx_diff(fx_diff($signed(rates.gen_v), recomb), loss_v);
    r.interstitial     = fx_sum(ci, fx_product(rate_i, rates.tstep));
    r.vacancy          = fx_sum(cv, fx_product(rate_v, rates.tstep));
    r.saturated        = clamp_seen;
    interstitial_level = r.interstitial;
    vacancy_level      = r.vacancy;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: result %0d: %s", taken, msg);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic signed [31:0] got,
                             input logic signed [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got, exp_val));
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    taken      = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rates.gen_i        = 32'(((1 << FRAC_BITS) + 5) / 10);
      rates.gen_v        = 32'(((1 << FRAC_BITS) + 5) / 10);
      rates.recomb       = 31'((1 << FRAC_BITS) / 2);
      rates.loss_i       = '0;
      rates.loss_v       = '0;
      rates.tstep        = 31'(((1 << FRAC_BITS) + 50) / 100);
      interstitial_level = '0;
      vacancy_level      = '0;
      step_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GEN_I: begin
            rates.gen_i = cfg_wdata;
          end
          REG_GEN_V: begin
            rates.gen_v = cfg_wdata;
          end
          REG_RECOMB: begin
            rates.recomb = cfg_wdata[30:0];
          end
          REG_LOSS_I: begin
            rates.loss_i = cfg_wdata[30:0];
          end
          REG_LOSS_V: begin
            rates.loss_v = cfg_wdata[30:0];
          end
          REG_TSTEP: begin
            rates.tstep = cfg_wdata[30:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (step_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = step_q.pop_front();
          check_field("interstitial_conc", out_interstitial_conc, want.interstitial);
          check_field("vacancy_conc", out_vacancy_conc, want.vacancy);
          check_field("saturated", {31'b0, out_saturated}, {31'b0, want.saturated});
        end
        taken++;
      end
      if (in_valid && in_ready) begin
        step_q.push_back(predict_step(in_restart));
      end
    end
    pending = step_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// testbench top for the point defect rate euler step core: drives register writes,
// step items and result back-pressure, and gives the verdict from pdre_step_checker
// depends on pdre_pkg, point_defect_rate_euler_step_core and pdre_step_checker
module tb;
  import pdre_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_STEPS   = 50;
  localparam int HOLD_CYCLES   = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_restart = 1'b0;
  logic                 out_ready  = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [31:0]   out_interstitial_conc;
  logic signed [31:0]   out_vacancy_conc;
  logic                 out_saturated;
  int                   fail_count;
  int                   pending_steps;
  int                   in_gap_max  = 0;
  int                   out_gap_max = 0;

  always #10 clk = ~clk;

  point_defect_rate_euler_step_core #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_interstitial_conc(out_interstitial_conc),
    .out_vacancy_conc     (out_vacancy_conc),
    .out_saturated        (out_saturated)
  );

  pdre_step_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_interstitial_conc(out_interstitial_conc),
    .out_vacancy_conc     (out_vacancy_conc),
    .out_saturated        (out_saturated),
    .fail_count           (fail_count),
    .pending              (pending_steps)
  );

  // enable stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_rates(input logic [31:0] gen_i, input logic [31:0] gen_v,
                               input logic [31:0] recomb, input logic [31:0] loss_i,
                               input logic [31:0] loss_v, input logic [31:0] tstep);
    write_reg(REG_GEN_I, gen_i);
    write_reg(REG_GEN_V, gen_v);
    write_reg(REG_RECOMB, recomb);
    write_reg(REG_LOSS_I, loss_i);
    write_reg(REG_LOSS_V, loss_v);
    write_reg(REG_TSTEP, tstep);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_step(input logic restart);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // block idle once every outstanding step has returned
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_steps != 0);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] draw_reg(input bit signed_reg);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: begin
        v = signed_reg ? FX_MIN : {$urandom_range(0, 1) == 1, 31'h0};
      end
      1: begin
        v = signed_reg ? FX_MAX : {$urandom_range(0, 1) == 1, 31'h7fff_ffff};
      end
      2: begin
        v = $urandom();
      end
      default: begin
        v = signed_reg ? $urandom_range(0, 1 << 18) - (1 << 17) : $urandom_range(0, 1 << 17);
      end
    endcase
    return v;
  endfunction

  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      // long hold so the core fills up and stalls its input
      if (taken == 150 || taken == 450) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default rates from reset
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    settle();

    // writes to unused indexes change nothing
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'h0);
    cfg_wr_en <= 1'b0;
    send_step(1'b0);
    send_step(1'b0);
    settle();

    // positive saturation, bit 31 of unsigned registers ignored
    program_rates(FX_MAX, FX_MAX, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    settle();

    // negative saturation with every loss at full scale
    program_rates(FX_MIN, FX_MIN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff);
    send_step(1'b1);
    repeat (2) send_step(1'b0);
    settle();

    // negative products floor towards minus infinity
    program_rates(32'hffff_ffff, 32'hffff_fffd, 32'h0, 32'h0, 32'h0, 32'h1);
    send_step(1'b1);
    send_step(1'b0);
    settle();

    program_rates(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_step(1'b0);
    send_step(1'b1);
    settle();

    // loss dominated decay
    program_rates(32'd65536, 32'd32768, 32'd16384, 32'd196608, 32'd65536, 32'd16384);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 9;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
      end
      program_rates(draw_reg(1'b1), draw_reg(1'b1), draw_reg(1'b0), draw_reg(1'b0),
                    draw_reg(1'b0), draw_reg(1'b0));
      for (int n = 0; n < PHASE_STEPS; n++) begin
        send_step((n == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 15) == 0));
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pdre_pkg.sv
hdl/pdre_cfg.sv
hdl/pdre_mul.sv
hdl/pdre_seq.sv
hdl/point_defect_rate_euler_step_core.sv
dv/pdre_step_checker.sv
dv/tb.sv
